// File: rtl/wmft_pkg.sv
package wmft_pkg;

	localparam int WORDS_PER_FRAME = 12;
	localparam int WFRAC           = 22;
	localparam int DIV_W           = 64;

	localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
	localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_XFORM = 1'b1;

	localparam logic [1:0] REG_GRID_X = 2'd0;
	localparam logic [1:0] REG_GRID_Y = 2'd1;
	localparam logic [1:0] REG_ACTIVE = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ORG_RD,
		ST_ORG_SUB,
		ST_SQ_MUL,
		ST_SQ_ACC,
		ST_MX_RD,
		ST_MX_MUL,
		ST_MX_ACC,
		ST_MIRROR,
		ST_W_DIV,
		ST_WR_MUL,
		ST_WR_ACC,
		ST_FIN,
		ST_FIN_WAIT,
		ST_DONE
	} st_t;

	typedef struct packed {
		logic [30:0] grid_x;
		logic [30:0] grid_y;
		logic [2:0]  active;
	} cfg_t;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		logic               flag;
	} res_t;

	typedef struct packed {
		logic              start;
		logic [DIV_W-1:0]  dividend;
		logic [DIV_W-1:0]  divisor;
		logic [6:0]        steps;
	} div_req_t;

	function automatic logic ovf32(input logic signed [63:0] v);
		return (v > S32_MAX) || (v < S32_MIN);
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [63:0] t;
		t = v;
		if (v > S32_MAX) t = S32_MAX;
		if (v < S32_MIN) t = S32_MIN;
		return t[31:0];
	endfunction

endpackage

// File: rtl/wmft_table.sv
module wmft_table #(
	parameter int DEPTH = 48,
	parameter int AW    = 6
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [31:0]   wr_data,
	input  logic [AW-1:0] rd_addr,
	output logic [31:0]   rd_data
);

	logic [31:0]      mem [DEPTH];
	logic [DEPTH-1:0] valid_q;
	logic [31:0]      rd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q <= valid_q[rd_addr] ? mem[rd_addr] : 32'd0;
	end

	assign rd_data = rd_q;

endmodule

// File: rtl/wmft_div.sv
module wmft_div (
	input  logic                   clk,
	input  logic                   arst_n,
	input  wmft_pkg::div_req_t     req,
	output logic                   done,
	output logic [wmft_pkg::DIV_W-1:0] quot
);

	localparam int W = wmft_pkg::DIV_W;

	logic [W-1:0] dq_q;
	logic [W-1:0] rem_q;
	logic [W-1:0] dvs_q;
	logic [6:0]   cnt_q;
	logic         run_q;
	logic         done_q;
	logic [W:0]   trial;
	logic [W:0]   diff;
	logic         take;

	always_comb begin
		trial = {rem_q, dq_q[W-1]};
		diff  = trial - {1'b0, dvs_q};
		take  = trial >= {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				run_q <= 1'b1;
				cnt_q <= req.steps;
			end else if (run_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dq_q  <= req.dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (run_q) begin
			rem_q <= take ? diff[W-1:0] : trial[W-1:0];
			dq_q  <= {dq_q[W-2:0], take};
		end
	end

	assign done = done_q;
	assign quot = dq_q;

endmodule

// File: rtl/wmft_seq.sv
module wmft_seq #(
	parameter int MAX_FRAMES = 4,
	parameter int FRAC_BITS  = 16,
	parameter int AW         = 6
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic signed [31:0]  pt_x,
	input  logic signed [31:0]  pt_y,
	input  logic signed [31:0]  pt_z,
	input  wmft_pkg::cfg_t      cfg,
	output logic [AW-1:0]       rd_addr,
	input  logic [31:0]         rd_data,
	output logic                idle,
	output logic                res_valid,
	output wmft_pkg::res_t      res,
	input  logic                res_ack
);

	localparam int KW  = $clog2(MAX_FRAMES + 1);
	localparam int EPS = ((1 << FRAC_BITS) + 50) / 100;
	localparam int WSTEPS = FRAC_BITS + wmft_pkg::WFRAC + 1;

	wmft_pkg::st_t state_q, state_d;

	logic [1:0]         cnt_q, row_q, col_q;
	logic [KW-1:0]      k_q, n_now;
	logic [KW-1:0]      n_q, n_q_eq;
	logic signed [31:0] p_q   [3];
	logic signed [31:0] a_q   [3];
	logic signed [63:0] r_q   [3];
	logic signed [31:0] rs_q  [3];
	logic signed [63:0] acc_q [3];
	logic signed [31:0] res_q [3];
	logic [63:0]        d2_q;
	logic [31:0]        w_q;
	logic [31:0]        wsum_q;
	logic               flag_q;
	logic signed [63:0] prod_q;

	logic signed [32:0] mul_a, mul_b;
	logic [1:0]         a_sel;
	logic [7:0]         addr_sum;
	logic [3:0]         off;
	logic               last3, last_frame, div_done;
	logic [63:0]        div_quot;
	wmft_pkg::div_req_t div_req;
	logic signed [63:0] sub_v, m0, m1, m2, acc_cur, mag;
	logic signed [63:0] q_s, q_neg;

	wmft_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.done   (div_done),
		.quot   (div_quot)
	);

	always_comb begin
		n_now = (cfg.active > 3'(MAX_FRAMES)) ? KW'(MAX_FRAMES) : KW'(cfg.active);
		last3 = (cnt_q == 2'd2);
		last_frame = ((k_q + KW'(1)) == n_q_eq);
	end

	assign n_q_eq = n_q;

	always_comb begin
		off = (state_q == wmft_pkg::ST_ORG_RD) ? (4'd9 + 4'(cnt_q))
		                                       : (4'(row_q) * 4'd3 + 4'(col_q));
		addr_sum = 8'(k_q) * 8'(wmft_pkg::WORDS_PER_FRAME) + 8'(off);
		rd_addr  = addr_sum[AW-1:0];
	end

	always_comb begin
		a_sel = (state_q == wmft_pkg::ST_MX_MUL) ? col_q : cnt_q;
		mul_a = 33'(signed'(a_q[a_sel]));
		mul_b = 33'(signed'(a_q[a_sel]));
		case (state_q)
			wmft_pkg::ST_MX_MUL: mul_a = 33'(signed'(rd_data));
			wmft_pkg::ST_WR_MUL: begin
				mul_a = $signed({1'b0, w_q});
				mul_b = 33'(rs_q[cnt_q]);
			end
			default: ;
		endcase
	end

	always_comb begin
		sub_v = 64'(p_q[cnt_q]) - 64'(signed'(rd_data));
		m0 = k_q[0] ? ($signed({33'd0, cfg.grid_x}) - r_q[0]) : r_q[0];
		m1 = (8'(k_q) >= 8'd2) ? ($signed({33'd0, cfg.grid_y}) - r_q[1]) : r_q[1];
		m2 = ((8'(k_q) == 8'd0) || (8'(k_q) == 8'd3)) ? -r_q[2] : r_q[2];
		acc_cur = acc_q[cnt_q];
		mag     = acc_cur[63] ? -acc_cur : acc_cur;
		q_s     = $signed(div_quot);
		q_neg   = -q_s;
	end

	always_comb begin
		div_req.start    = 1'b0;
		div_req.dividend = 64'h8000_0000_0000_0000;
		div_req.divisor  = d2_q + 64'(EPS);
		div_req.steps    = 7'(WSTEPS);
		if (state_q == wmft_pkg::ST_MIRROR) begin
			div_req.start = 1'b1;
		end
		if (state_q == wmft_pkg::ST_FIN) begin
			div_req.start    = (wsum_q != 32'd0);
			div_req.dividend = mag;
			div_req.divisor  = {32'd0, wsum_q};
			div_req.steps    = 7'd64;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			wmft_pkg::ST_IDLE: begin
				if (start) begin
					state_d = (n_now == '0) ? wmft_pkg::ST_FIN : wmft_pkg::ST_ORG_RD;
				end
			end
			wmft_pkg::ST_ORG_RD:  state_d = wmft_pkg::ST_ORG_SUB;
			wmft_pkg::ST_ORG_SUB: state_d = last3 ? wmft_pkg::ST_SQ_MUL : wmft_pkg::ST_ORG_RD;
			wmft_pkg::ST_SQ_MUL:  state_d = wmft_pkg::ST_SQ_ACC;
			wmft_pkg::ST_SQ_ACC:  state_d = last3 ? wmft_pkg::ST_MX_RD : wmft_pkg::ST_SQ_MUL;
			wmft_pkg::ST_MX_RD:   state_d = wmft_pkg::ST_MX_MUL;
			wmft_pkg::ST_MX_MUL:  state_d = wmft_pkg::ST_MX_ACC;
			wmft_pkg::ST_MX_ACC: begin
				state_d = ((row_q == 2'd2) && (col_q == 2'd2)) ? wmft_pkg::ST_MIRROR
				                                              : wmft_pkg::ST_MX_RD;
			end
			wmft_pkg::ST_MIRROR: state_d = wmft_pkg::ST_W_DIV;
			wmft_pkg::ST_W_DIV: begin
				if (div_done) state_d = wmft_pkg::ST_WR_MUL;
			end
			wmft_pkg::ST_WR_MUL: state_d = wmft_pkg::ST_WR_ACC;
			wmft_pkg::ST_WR_ACC: begin
				if (last3) begin
					state_d = last_frame ? wmft_pkg::ST_FIN : wmft_pkg::ST_ORG_RD;
				end else begin
					state_d = wmft_pkg::ST_WR_MUL;
				end
			end
			wmft_pkg::ST_FIN: begin
				state_d = (wsum_q == 32'd0) ? wmft_pkg::ST_DONE : wmft_pkg::ST_FIN_WAIT;
			end
			wmft_pkg::ST_FIN_WAIT: begin
				if (div_done) state_d = last3 ? wmft_pkg::ST_DONE : wmft_pkg::ST_FIN;
			end
			wmft_pkg::ST_DONE: begin
				if (res_ack) state_d = wmft_pkg::ST_IDLE;
			end
			default: state_d = wmft_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wmft_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= 64'(mul_a) * 64'(mul_b);
		case (state_q)
			wmft_pkg::ST_IDLE: begin
				p_q[0] <= pt_x;
				p_q[1] <= pt_y;
				p_q[2] <= pt_z;
				n_q    <= n_now;
				k_q    <= '0;
				cnt_q  <= 2'd0;
				flag_q <= 1'b0;
				wsum_q <= '0;
				d2_q   <= '0;
				acc_q[0] <= '0;
				acc_q[1] <= '0;
				acc_q[2] <= '0;
				res_q[0] <= '0;
				res_q[1] <= '0;
				res_q[2] <= '0;
			end
			wmft_pkg::ST_ORG_SUB: begin
				a_q[cnt_q] <= wmft_pkg::sat32(sub_v);
				flag_q     <= flag_q | wmft_pkg::ovf32(sub_v);
				cnt_q      <= last3 ? 2'd0 : cnt_q + 2'd1;
			end
			wmft_pkg::ST_SQ_ACC: begin
				d2_q  <= d2_q + ($unsigned(prod_q) >> FRAC_BITS);
				cnt_q <= last3 ? 2'd0 : cnt_q + 2'd1;
				row_q <= 2'd0;
				col_q <= 2'd0;
				r_q[0] <= '0;
				r_q[1] <= '0;
				r_q[2] <= '0;
			end
			wmft_pkg::ST_MX_ACC: begin
				r_q[row_q] <= r_q[row_q] + (prod_q >>> FRAC_BITS);
				if (col_q == 2'd2) begin
					col_q <= 2'd0;
					row_q <= row_q + 2'd1;
				end else begin
					col_q <= col_q + 2'd1;
				end
			end
			wmft_pkg::ST_MIRROR: begin
				rs_q[0] <= wmft_pkg::sat32(m0);
				rs_q[1] <= wmft_pkg::sat32(m1);
				rs_q[2] <= wmft_pkg::sat32(m2);
				flag_q  <= flag_q | wmft_pkg::ovf32(m0) | wmft_pkg::ovf32(m1)
				           | wmft_pkg::ovf32(m2);
			end
			wmft_pkg::ST_W_DIV: begin
				w_q   <= div_quot[31:0];
				cnt_q <= 2'd0;
			end
			wmft_pkg::ST_WR_ACC: begin
				acc_q[cnt_q] <= acc_q[cnt_q] + prod_q;
				cnt_q        <= last3 ? 2'd0 : cnt_q + 2'd1;
				if (last3) begin
					wsum_q <= wsum_q + w_q;
					k_q    <= k_q + KW'(1);
					d2_q   <= '0;
				end
			end
			wmft_pkg::ST_FIN: begin
				if (wsum_q == 32'd0) flag_q <= 1'b1;
			end
			wmft_pkg::ST_FIN_WAIT: begin
				if (div_done) begin
					if (acc_cur[63]) begin
						res_q[cnt_q] <= wmft_pkg::sat32(q_neg);
						flag_q       <= flag_q | (div_quot > 64'h8000_0000);
					end else begin
						res_q[cnt_q] <= wmft_pkg::sat32(q_s);
						flag_q       <= flag_q | (div_quot > 64'h7FFF_FFFF);
					end
					cnt_q <= cnt_q + 2'd1;
				end
			end
			default: ;
		endcase
	end

	assign idle      = (state_q == wmft_pkg::ST_IDLE);
	assign res_valid = (state_q == wmft_pkg::ST_DONE);
	assign res.x     = res_q[0];
	assign res.y     = res_q[1];
	assign res.z     = res_q[2];
	assign res.flag  = flag_q;

endmodule

// File: rtl/weighted_multi_frame_transform.sv
// Weighted multi-frame point transform, signed fixed point with FRAC_BITS fraction bits.
// Input channel (in_valid/in_stall): a beat carries a command. A load beat writes one
// table word and is done in the cycle it is taken; an index past the table is dropped.
// A transform beat starts the sequencer, and in_stall stays high until its result has
// moved into the output register.
// Output channel (out_valid/out_stall): one beat per transform, none per load. The
// output register holds while out_stall is high; the next item may be taken meanwhile.
// One 33x33 multiplier handles every product one at a time, and a one-bit-per-cycle
// divider forms each weight and the three final quotients.
// Throughput: one transform at a time.
// APB registers: grid_dim_x at 0x0, grid_dim_y at 0x4, active_frames at 0x8; write only
// while the block is idle.
// Reset clears the table to zero (per-word valid bits), the registers to their defaults
// and both channels to empty.
module weighted_multi_frame_transform #(
	parameter int MAX_FRAMES = 4,
	parameter int FRAC_BITS  = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               command,
	input  logic [5:0]         table_index,
	input  logic signed [31:0] table_value,
	input  logic signed [31:0] point_x,
	input  logic signed [31:0] point_y,
	input  logic signed [31:0] point_z,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] out_x,
	output logic signed [31:0] out_y,
	output logic signed [31:0] out_z,
	output logic               range_flag
);

	localparam int DEPTH = wmft_pkg::WORDS_PER_FRAME * MAX_FRAMES;
	localparam int AW    = $clog2(DEPTH);

	wmft_pkg::cfg_t cfg_q;
	wmft_pkg::res_t res, out_q;
	logic           out_valid_q, seq_idle, res_valid, res_ack, in_acc, wr_en, cfg_wr;
	logic [AW-1:0]  rd_addr;
	logic [31:0]    rd_data;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.grid_x <= 31'd65536;
			cfg_q.grid_y <= 31'd65536;
			cfg_q.active <= 3'd4;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				wmft_pkg::REG_GRID_X: cfg_q.grid_x <= pwdata[30:0];
				wmft_pkg::REG_GRID_Y: cfg_q.grid_y <= pwdata[30:0];
				wmft_pkg::REG_ACTIVE: cfg_q.active <= pwdata[2:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			wmft_pkg::REG_GRID_X: prdata = {1'b0, cfg_q.grid_x};
			wmft_pkg::REG_GRID_Y: prdata = {1'b0, cfg_q.grid_y};
			wmft_pkg::REG_ACTIVE: prdata = {29'd0, cfg_q.active};
			default:              prdata = 32'd0;
		endcase
	end

	assign in_stall = !seq_idle;
	assign in_acc   = in_valid && !in_stall;
	assign wr_en    = in_acc && (command == wmft_pkg::CMD_LOAD)
	                  && ({1'b0, table_index} < 7'(DEPTH));

	wmft_table #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_addr (table_index[AW-1:0]),
		.wr_data (table_value),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	wmft_seq #(
		.MAX_FRAMES (MAX_FRAMES),
		.FRAC_BITS  (FRAC_BITS),
		.AW         (AW)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (in_acc && (command == wmft_pkg::CMD_XFORM)),
		.pt_x      (point_x),
		.pt_y      (point_y),
		.pt_z      (point_z),
		.cfg       (cfg_q),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data),
		.idle      (seq_idle),
		.res_valid (res_valid),
		.res       (res),
		.res_ack   (res_ack)
	);

	assign res_ack = res_valid && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ack) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ack) begin
			out_q <= res;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_x      = out_q.x;
	assign out_y      = out_q.y;
	assign out_z      = out_q.z;
	assign range_flag = out_q.flag;

endmodule

// File: rtl/wmft_chk.sv
module wmft_chk (
	input logic               clk,
	input logic               arst_n,
	input logic               psel,
	input logic               penable,
	input logic               pwrite,
	input logic [3:0]         paddr,
	input logic [31:0]        pwdata,
	input logic [31:0]        prdata,
	input logic               pready,
	input logic               in_valid,
	input logic               in_stall,
	input logic               command,
	input logic [5:0]         table_index,
	input logic signed [31:0] table_value,
	input logic signed [31:0] point_x,
	input logic signed [31:0] point_y,
	input logic signed [31:0] point_z,
	input logic               out_valid,
	input logic               out_stall,
	input logic signed [31:0] out_x,
	input logic signed [31:0] out_y,
	input logic signed [31:0] out_z,
	input logic               range_flag
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_x) && $stable(out_y)
		&& $stable(out_z) && $stable(range_flag))
		else $error("output beat changed while stalled");

	a_xform_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (command == wmft_pkg::CMD_XFORM) |=> in_stall)
		else $error("transform beat did not make the block busy");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (command == wmft_pkg::CMD_LOAD) |=> !in_stall)
		else $error("load beat made the block busy");

	a_out_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared without a transform in progress");

endmodule

bind weighted_multi_frame_transform wmft_chk u_wmft_chk (.*);

// File: bench/tb_weighted_multi_frame_transform.sv
`timescale 1ns / 1ps

module tb_weighted_multi_frame_transform;

	class point_scoreboard;
		logic signed [31:0] frame_words[12*4];
		logic [30:0] grid_x;
		logic [30:0] grid_y;
		logic [2:0] active;
		wmft_pkg::res_t expected_q[$];
		int errors;

		function new();
			foreach (frame_words[i]) frame_words[i] = '0;
			grid_x = 31'd65536;
			grid_y = 31'd65536;
			active = 3'd4;
			errors = 0;
		endfunction

		function void write_reg(logic [1:0] idx, logic [31:0] data);
			case (idx)
				wmft_pkg::REG_GRID_X: grid_x = data[30:0];
				wmft_pkg::REG_GRID_Y: grid_y = data[30:0];
				wmft_pkg::REG_ACTIVE: active = data[2:0];
				default: ;
			endcase
		endfunction

		function longint clamp32(longint v, inout bit flag);
			if (v > 64'sd2147483647) begin
				flag = 1'b1;
				return 64'sd2147483647;
			end
			if (v < -64'sd2147483648) begin
				flag = 1'b1;
				return -64'sd2147483648;
			end
			return v;
		endfunction

		function wmft_pkg::res_t blend_point(logic signed [31:0] px, logic signed [31:0] py,
				logic signed [31:0] pz);
			longint p[3];
			longint a[3];
			longint r[3];
			longint acc[3];
			longint wsum;
			longint w;
			longint d2;
			longint s;
			int n;
			bit flag;
			wmft_pkg::res_t res;
			p[0] = longint'(px);
			p[1] = longint'(py);
			p[2] = longint'(pz);
			acc = '{0, 0, 0};
			wsum = 0;
			flag = 1'b0;
			n = (active > 3'd4) ? 4 : int'(active);
			for (int k = 0; k < n; k++) begin
				d2 = 0;
				for (int i = 0; i < 3; i++) begin
					a[i] = clamp32(p[i] - longint'(frame_words[k*12 + 9 + i]), flag);
					d2 += (a[i] * a[i]) >> 16;
				end
				for (int i = 0; i < 3; i++) begin
					s = 0;
					for (int j = 0; j < 3; j++)
						s += (longint'(frame_words[k*12 + i*3 + j]) * a[j]) >>> 16;
					r[i] = s;
				end
				if (k % 2 == 1) r[0] = longint'(grid_x) - r[0];
				if (k >= 2) r[1] = longint'(grid_y) - r[1];
				if (k == 0 || k == 3) r[2] = -r[2];
				w = (64'sd1 << 38) / (d2 + 655);
				for (int i = 0; i < 3; i++)
					acc[i] += w * clamp32(r[i], flag);
				wsum += w;
			end
			res.x = '0;
			res.y = '0;
			res.z = '0;
			if (wsum == 0) begin
				flag = 1'b1;
			end else begin
				res.x = 32'(clamp32(acc[0] / wsum, flag));
				res.y = 32'(clamp32(acc[1] / wsum, flag));
				res.z = 32'(clamp32(acc[2] / wsum, flag));
			end
			res.flag = flag;
			return res;
		endfunction

		function void note_input(logic cmd, logic [5:0] idx, logic signed [31:0] val,
				logic signed [31:0] px, logic signed [31:0] py, logic signed [31:0] pz);
			if (cmd == wmft_pkg::CMD_LOAD) begin
				if (idx < 6'd48) frame_words[idx] = val;
			end else begin
				expected_q.push_back(blend_point(px, py, pz));
			end
		endfunction

		task report(string what, longint got, longint want);
			$display("mismatch %s: got %0d want %0d", what, got, want);
			errors++;
		endtask

		task check_result(wmft_pkg::res_t got);
			wmft_pkg::res_t want;
			if (expected_q.size() == 0) begin
				report("unexpected beat out_x", got.x, 0);
			end else begin
				want = expected_q.pop_front();
				if (got.x !== want.x) report("out_x", got.x, want.x);
				if (got.y !== want.y) report("out_y", got.y, want.y);
				if (got.z !== want.z) report("out_z", got.z, want.z);
				if (got.flag !== want.flag) report("range_flag", got.flag, want.flag);
			end
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [3:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_stall;
	logic command = wmft_pkg::CMD_LOAD;
	logic [5:0] table_index = '0;
	logic signed [31:0] table_value = '0;
	logic signed [31:0] point_x = '0;
	logic signed [31:0] point_y = '0;
	logic signed [31:0] point_z = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [31:0] out_x;
	logic signed [31:0] out_y;
	logic signed [31:0] out_z;
	logic range_flag;

	point_scoreboard sb = new();
	bit quiet = 1'b0;
	int stall_left = 0;

	weighted_multi_frame_transform i_dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall),
		.command(command), .table_index(table_index), .table_value(table_value),
		.point_x(point_x), .point_y(point_y), .point_z(point_z),
		.out_valid(out_valid), .out_stall(out_stall),
		.out_x(out_x), .out_y(out_y), .out_z(out_z), .range_flag(range_flag)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall)
				sb.check_result('{x: out_x, y: out_y, z: out_z, flag: range_flag});
			if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				out_stall <= 1'b1;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				stall_left <= $urandom_range(0, 15);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	task apb_write(logic [1:0] idx, logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		sb.write_reg(idx, data);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task send_beat(logic cmd, logic [5:0] idx, logic signed [31:0] val,
			logic signed [31:0] px, logic signed [31:0] py, logic signed [31:0] pz);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		command <= cmd;
		table_index <= idx;
		table_value <= val;
		point_x <= px;
		point_y <= py;
		point_z <= pz;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		sb.note_input(cmd, idx, val, px, py, pz);
	endtask

	task load_word(logic [5:0] idx, logic signed [31:0] val);
		send_beat(wmft_pkg::CMD_LOAD, idx, val, $urandom, $urandom, $urandom);
	endtask

	task transform(logic signed [31:0] px, logic signed [31:0] py, logic signed [31:0] pz);
		send_beat(wmft_pkg::CMD_XFORM, 6'($urandom), $urandom, px, py, pz);
	endtask

	task drain();
		in_valid <= 1'b0;
		while (sb.expected_q.size() > 0) @(posedge clk);
		repeat (600) @(posedge clk);
	endtask

	function logic signed [31:0] rand_word();
		if ($urandom_range(0, 3) == 0) return $urandom;
		return $signed($urandom_range(0, 262143)) - 131072;
	endfunction

	function logic [31:0] rand_grid();
		case ($urandom_range(0, 3))
			0: return 32'd0;
			1: return 32'h7FFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	initial begin
		#20_000_000;
		$display("weighted_multi_frame_transform regression: fail");
		$finish;
	end

	initial begin
		logic [2:0] act;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		transform(32'sd65536, -32'sd65536, 32'sd3);
		load_word(6'd0, 32'sd65536);
		load_word(6'd4, 32'sd65536);
		load_word(6'd8, 32'sd65536);
		load_word(6'd12, 32'sh7FFF_FFFF);
		load_word(6'd16, -32'sd65536);
		load_word(6'd33, 32'sh8000_0000);
		load_word(6'd47, 32'sh1234_5678);
		load_word(6'd48, 32'sd99);
		load_word(6'd63, -32'sd1);
		transform(32'sd0, 32'sd0, 32'sd0);
		transform(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
		transform(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
		transform(32'sd131072, -32'sd70000, 32'sd12345);
		drain();
		apb_write(wmft_pkg::REG_ACTIVE, 32'd0);
		apb_write(wmft_pkg::REG_GRID_X, 32'h7FFF_FFFF);
		apb_write(wmft_pkg::REG_GRID_Y, 32'd0);
		transform(32'sd1000, 32'sd2000, 32'sd3000);
		drain();
		apb_write(wmft_pkg::REG_ACTIVE, 32'd7);
		transform(32'sd1000, -32'sd2000, 32'sd3000);
		transform(32'sh7FFF_FFFF, 32'sd0, 32'sh8000_0000);
		drain();
		apb_write(wmft_pkg::REG_ACTIVE, 32'd1);
		apb_write(wmft_pkg::REG_GRID_Y, 32'h7FFF_FFFF);
		transform(-32'sd5000, 32'sd5000, 32'sd0);
		drain();

		for (int ph = 0; ph < 5; ph++) begin
			act = ($urandom_range(0, 4) == 0) ? 3'($urandom_range(0, 7))
				: 3'($urandom_range(1, 4));
			if (ph == 4) act = 3'd4;
			apb_write(wmft_pkg::REG_GRID_X, rand_grid());
			apb_write(wmft_pkg::REG_GRID_Y, rand_grid());
			apb_write(wmft_pkg::REG_ACTIVE, {29'd0, act});
			if (ph == 4) quiet = 1'b1;
			for (int i = 0; i < 105; i++) begin
				if ($urandom_range(0, 9) < 4)
					load_word(6'($urandom_range(0, ($urandom_range(0, 7) == 0) ? 63 : 47)),
						rand_word());
				else if ($urandom_range(0, 3) == 0)
					transform($urandom, $urandom, $urandom);
				else
					transform($signed($urandom_range(0, 524287)) - 262144,
						$signed($urandom_range(0, 524287)) - 262144,
						$signed($urandom_range(0, 524287)) - 262144);
			end
			drain();
		end

		if (sb.errors == 0 && sb.expected_q.size() == 0) begin
			$display("weighted_multi_frame_transform regression: pass");
		end else begin
			$display("weighted_multi_frame_transform regression: fail");
		end
		$finish;
	end

endmodule
